// File: hw/rtl/dpd_pkg.sv
// shared types, constants and helpers for the digitizer packet deframer
`timescale 1ns / 1ps

package dpd_pkg;

    localparam logic [31:0] DIG_MARKER  = 32'hAAAA_AAAA;
    localparam logic [31:0] TRIG_MARKER = 32'hAAAA_0000;
    localparam int          TRIG_PKT_WORDS = 16;
    localparam int          TRIG_OUT_WORDS = 10;
    localparam logic [11:0] TRIG_BOARD   = 12'd99;
    localparam logic [3:0]  CH_RUN_DONE  = 4'hD;
    localparam logic [3:0]  CH_SPECIAL   = 4'd10;

    typedef enum logic [2:0] {
        KIND_WORD       = 3'd0,
        KIND_BATCH_GOOD = 3'd1,
        KIND_RUN_DONE   = 3'd2,
        KIND_DIG_TRUNC  = 3'd3,
        KIND_TRIG_TRUNC = 3'd4,
        KIND_UNKNOWN    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_MARKER = 3'd0,
        PH_HEADER = 3'd1,
        PH_BODY   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_TRIG   = 3'd4,
        PH_DROP   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [31:0] word;
        logic        end_of_batch;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_word;
        logic [11:0] board;
        logic [3:0]  channel;
        logic        from_trigger;
        logic        packet_end;
        logic        last_result;
    } t_out_item;

    // everything one input beat leaves for the output side
    typedef struct packed {
        logic                              valid;
        logic [3:0]                        pk_cnt;
        logic [TRIG_OUT_WORDS-1:0][31:0]   words;
        logic [11:0]                       board;
        logic [3:0]                        channel;
        logic                              from_trigger;
        logic                              end_last;
        logic                              tail_valid;
        t_kind                             tail_kind;
    } t_load;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// File: hw/rtl/digitizer_packet_deframer.sv
// top level: packet parser state machine feeding the result queue
// latency: first result of a beat is shown the cycle after the beat is taken
// throughput: one result per cycle unless the output stalls; the input is held
// until a beat's last result leaves; beats with <= 1 result stream every cycle
// a completed trigger packet yields up to 11 results from its last beat
// reset (synchronous, active low): parser expects a marker, result queue empty
`timescale 1ns / 1ps

module digitizer_packet_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dpd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dpd_pkg::t_out_item  o_out_data
);
    import dpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [10:0] r_left,  n_left;
    logic [3:0]  r_pos,   n_pos;
    logic [11:0] r_board, n_board;
    logic [3:0]  r_ch,    n_ch;
    logic [31:0] r_trig [TRIG_PKT_WORDS-3:0];

    logic        ready;
    logic        acc;
    t_load       ld;
    logic        trig_we;
    logic [3:0]  trig_idx;
    logic [31:0] hw;
    logic [3:0]  h_ch;
    logic [10:0] len_eff;
    logic [10:0] left_dec;
    logic [3:0]  pos_eff;
    logic [31:0] h [TRIG_PKT_WORDS-1:1];

    assign acc        = i_in_valid && ready;
    assign o_in_stall = !ready;
    assign hw         = swap32(i_in_data.word);
    assign h_ch       = hw[3:0];
    assign len_eff    = (hw[26:16] < 11'd2) ? 11'd2 : hw[26:16];
    assign left_dec   = (r_left != 11'd0) ? r_left - 11'd1 : r_left;
    assign pos_eff    = (r_pos == 4'd0) ? 4'd1 : r_pos;

    // header words of a trigger packet; the last one is the current beat
    always_comb begin
        for (int i = 1; i < TRIG_PKT_WORDS - 1; i++) begin
            h[i] = r_trig[i-1];
        end
        h[TRIG_PKT_WORDS-1] = hw;
    end

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_pos    = r_pos;
        n_board  = r_board;
        n_ch     = r_ch;
        trig_we  = 1'b0;
        trig_idx = pos_eff - 4'd1;
        ld       = '0;
        ld.tail_kind = KIND_BATCH_GOOD;

        unique case (r_phase)
            PH_MARKER: begin
                if (i_in_data.word == DIG_MARKER) begin
                    n_phase = PH_HEADER;
                end else if (i_in_data.word == TRIG_MARKER) begin
                    n_pos   = 4'd1;
                    n_phase = PH_TRIG;
                end else begin
                    ld.tail_valid = 1'b1;
                    ld.tail_kind  = KIND_UNKNOWN;
                    n_phase       = PH_DROP;
                end
            end
            PH_HEADER: begin
                if (h_ch >= CH_SPECIAL) begin
                    if (h_ch == CH_RUN_DONE) begin
                        ld.tail_valid = 1'b1;
                        ld.tail_kind  = KIND_RUN_DONE;
                        n_phase       = PH_DONE;
                    end else begin
                        n_left  = 11'd2;
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_ch        = h_ch;
                    n_board     = hw[15:4];
                    ld.pk_cnt   = 4'd2;
                    ld.words[0] = DIG_MARKER;
                    ld.words[1] = i_in_data.word;
                    ld.board    = hw[15:4];
                    ld.channel  = h_ch;
                    ld.end_last = (len_eff == 11'd2);
                    n_left      = len_eff - 11'd2;
                    n_phase     = (len_eff == 11'd2) ? PH_MARKER : PH_BODY;
                end
            end
            PH_BODY: begin
                n_left      = left_dec;
                ld.pk_cnt   = 4'd1;
                ld.words[0] = i_in_data.word;
                ld.board    = r_board;
                ld.channel  = r_ch;
                ld.end_last = (left_dec == 11'd0);
                if (left_dec == 11'd0) begin
                    n_phase = PH_MARKER;
                end
            end
            PH_SKIP: begin
                n_left = left_dec;
                if (left_dec == 11'd0) begin
                    n_phase = PH_MARKER;
                end
            end
            PH_TRIG: begin
                if (pos_eff == 4'(TRIG_PKT_WORDS - 1)) begin
                    ld.pk_cnt       = 4'(TRIG_OUT_WORDS);
                    ld.board        = TRIG_BOARD;
                    ld.channel      = 4'd0;
                    ld.from_trigger = 1'b1;
                    ld.end_last     = 1'b1;
                    ld.words[0]     = DIG_MARKER;
                    ld.words[1]     = {16'd10, 16'(TRIG_BOARD) << 4};
                    ld.words[2]     = h[4] | (h[3] << 16);
                    ld.words[3]     = h[2] | (32'hE << 16) | (32'd3 << 26);
                    ld.words[4]     = (h[1] << 16) + h[5];
                    for (int i = 1; i < 6; i++) begin
                        ld.words[4+i] = (h[4+2*i] << 16) + h[5+2*i];
                    end
                    n_pos   = 4'd0;
                    n_phase = PH_MARKER;
                end else begin
                    trig_we = 1'b1;
                    n_pos   = pos_eff + 4'd1;
                end
            end
            PH_DROP: begin
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // batch end closes whatever is open, except after a run-done header
        if (i_in_data.end_of_batch && n_phase != PH_DONE) begin
            unique case (n_phase)
                PH_MARKER, PH_SKIP: begin
                    ld.tail_valid = 1'b1;
                    ld.tail_kind  = KIND_BATCH_GOOD;
                end
                PH_HEADER, PH_BODY: begin
                    ld.tail_valid = 1'b1;
                    ld.tail_kind  = KIND_DIG_TRUNC;
                end
                PH_TRIG: begin
                    ld.tail_valid = 1'b1;
                    ld.tail_kind  = KIND_TRIG_TRUNC;
                end
                default: begin
                end
            endcase
            n_phase = PH_MARKER;
            n_left  = 11'd0;
            n_pos   = 4'd0;
        end

        ld.valid = acc && ((ld.pk_cnt != 4'd0) || ld.tail_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MARKER;
            r_left  <= '0;
            r_pos   <= '0;
            r_board <= '0;
            r_ch    <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_board <= n_board;
            r_ch    <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && trig_we) begin
            r_trig[trig_idx] <= hw;
        end
    end

    dpd_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ld        (ld),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/dpd_result_queue.sv
// holds one input beat's results, hands them out one per cycle unless stalled
`timescale 1ns / 1ps

module dpd_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dpd_pkg::t_load   i_ld,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output dpd_pkg::t_out_item o_out_data
);
    import dpd_pkg::*;

    logic       r_busy;
    logic [3:0] r_idx;
    t_load      r_ld;
    logic [3:0] total;
    logic       is_last;
    logic       done;

    assign total   = r_ld.pk_cnt + {3'b000, r_ld.tail_valid};
    assign is_last = (r_idx + 4'd1) == total;
    assign done    = r_busy && !i_out_stall && is_last;
    assign o_ready = !r_busy || done;
    assign o_out_valid = r_busy;

    always_comb begin
        o_out_data = '0;
        o_out_data.last_result = is_last;
        if (r_idx < r_ld.pk_cnt) begin
            o_out_data.kind         = KIND_WORD;
            o_out_data.out_word     = r_ld.words[r_idx];
            o_out_data.board        = r_ld.board;
            o_out_data.channel      = r_ld.channel;
            o_out_data.from_trigger = r_ld.from_trigger;
            o_out_data.packet_end   = r_ld.end_last && ((r_idx + 4'd1) == r_ld.pk_cnt);
        end else begin
            o_out_data.kind = r_ld.tail_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && !i_out_stall && !is_last) begin
            r_idx <= r_idx + 4'd1;
        end else if (o_ready) begin
            r_busy <= i_ld.valid;
            r_idx  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.valid) begin
            r_ld <= i_ld;
        end
    end

endmodule
